// ===== rtl/core/uart_frame_checker_responder_top_macros.svh =====
// Assertion macros shared by the frame checker RTL.
`ifndef UART_FRAME_CHECKER_RESPONDER_TOP_MACROS_SVH
`define UART_FRAME_CHECKER_RESPONDER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that cond holds at every clock edge outside reset.
`define UFCR_ASSERT(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("ufcr assertion failed");

// Checks that cons holds on the edge that follows one where ante holds.
`define UFCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ufcr assertion failed");

`else

`define UFCR_ASSERT(label, clk, rstn, cond)
`define UFCR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/ufcr_pkg.sv =====
// Types, constants and reply tables of the UART frame checker.
`default_nettype none

package ufcr_pkg;

  // Command codes carried in the fourth byte of a frame.
  localparam logic [7:0] CMD_SET_SIZE = 8'h0A;
  localparam logic [7:0] CMD_DATA     = 8'h0B;
  localparam logic [7:0] CMD_STATUS   = 8'h0C;
  localparam logic [7:0] CMD_INFO     = 8'h04;
  localparam logic [7:0] CMD_CONFIG   = 8'h0F;

  // Frame byte that holds the most significant byte of the file size.
  localparam logic [8:0] SIZE_IDX_FIRST = 9'd53;

  // Bytes of a frame beyond the payload: length, spare, checksum, command.
  localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

  // Entries in the job queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int unsigned REPLY_MAX = 17;
  localparam int unsigned REPLY_IW  = $clog2(REPLY_MAX);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_CSUM = 2'd1,
    STATUS_OVF  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REPLY_0A = 2'd0,
    REPLY_0B = 2'd1,
    REPLY_04 = 2'd2,
    REPLY_0F = 2'd3
  } reply_e;

  // One finished frame as handed from the front to the back.
  typedef struct packed {
    logic        is_reply;
    reply_e      reply;
    status_e     status;
    logic [7:0]  command;
    logic [31:0] image_pos;
    logic [31:0] image_len;
  } job_t;

  localparam logic [REPLY_IW-1:0] REPLY_LEN [4] = '{
    REPLY_IW'(9), REPLY_IW'(5), REPLY_IW'(12), REPLY_IW'(17)
  };

  // Fixed reply frames, padded with zeros to the longest one.
  localparam logic [7:0] REPLY_ROM [4][REPLY_MAX] = '{
    '{8'h05, 8'hAC, 8'h0A, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'hAC, 8'h0B, 8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h08, 8'hAC, 8'h3C, 8'h04, 8'h01, 8'h18, 8'h04, 8'h02, 8'h00,
      8'h19, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0D, 8'hAC, 8'h1B, 8'h0F, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h80,
      8'h00, 8'h71, 8'h00, 8'h0F, 8'h00, 8'h0E, 8'h00, 8'h7F}
  };

endpackage

`default_nettype wire

// ===== rtl/core/ufcr_rx_if.sv =====
// Receive channel: one serial byte per transaction.
`default_nettype none

interface ufcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ufcr_tx_if.sv =====
// Result channel: one reply byte or status report per transaction.
`default_nettype none

interface ufcr_tx_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [31:0] image_pos;
  logic [31:0] image_len;

  modport source (output valid, output tx_valid, output tx_byte, output last,
                  output status, output command, output image_pos,
                  output image_len, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input last,
                  input status, input command, input image_pos,
                  input image_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/uart_frame_checker_responder_top.sv =====
// Top level of the UART frame checker and responder.
//
// The block takes received serial bytes on the rx channel, one per transaction, and
// gathers them into frames: a length byte L, a spare byte, a checksum byte, a command
// byte and L further bytes. When a frame ends it reports on the tx channel, either
// as a fixed reply frame sent one byte per transaction (tx_valid high, last on the
// final byte) or as a single status transaction (tx_valid low, last high). Frames with
// a bad checksum report status 1; frames that run past FRAME_LIMIT bytes are dropped
// and report status 2.
// Throughput is one byte per cycle on each side when nothing stalls. The front end accepts
// a byte every cycle while its job queue has room; the back end emits one result per
// cycle from the head of the queue while tx ready is high, and a reply has up to 17
// bytes. The result of a frame is written into the queue when its final byte is accepted
// and is then loaded from the head of the queue into the output register.
// When the receiver holds tx ready low, the output register keeps its transaction, the
// queue fills, and once it holds four frames rx ready drops until room frees up.
// Reset clears all frame and image state and empties the queue.
`default_nettype none

`include "uart_frame_checker_responder_top_macros.svh"

module uart_frame_checker_responder_top #(
  parameter int unsigned FRAME_LIMIT = 255
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufcr_rx_if.sink   rx_i,
  ufcr_tx_if.source tx_o
);
  import ufcr_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic full;
  logic pop;
  logic empty;

  // Frame assembly, checksum check and command decode.
  ufcr_front #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // Finished frames wait here so that a stalled receiver does not stop reception at once.
  ufcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (empty)
  );

  // Reply expansion and the output register.
  ufcr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .tx      (tx_o)
  );

  // A frame result is never pushed into a full queue.
  `UFCR_ASSERT(a_no_push_when_full, clk_i, rst_ni, !(push && full))

  // A status-only transaction always closes its run.
  `UFCR_ASSERT(a_status_is_last, clk_i, rst_ni, !(tx_o.valid && !tx_o.tx_valid) || tx_o.last)

  // Error statuses never come with a reply byte.
  `UFCR_ASSERT(a_error_no_reply, clk_i, rst_ni,
               !(tx_o.valid && (tx_o.status != STATUS_OK)) || !tx_o.tx_valid)

  // A job popped from the queue was presented on the output in the next cycle.
  `UFCR_ASSERT_NEXT(a_pop_shows_output, clk_i, rst_ni, pop, tx_o.valid && tx_o.last)

endmodule

`default_nettype wire

// ===== rtl/core/ufcr_front.sv =====
// Front end: gathers received bytes into frames and classifies each frame.
`default_nettype none

module ufcr_front #(
  parameter int unsigned FRAME_LIMIT = 255
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ufcr_rx_if.sink           rx,
  input  wire logic         full_i,
  output logic              push_o,
  output ufcr_pkg::job_t    job_o
);
  import ufcr_pkg::*;

  logic [8:0]  byte_count_q, byte_count_d;
  logic [7:0]  frame_length_q, frame_length_d;
  logic [7:0]  expected_sum_q, expected_sum_d;
  logic [7:0]  command_q, command_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [31:0] size_capture_q, size_capture_d;
  logic [31:0] image_pos_q, image_pos_d;
  logic [31:0] image_len_q, image_len_d;

  logic       accept;
  logic       first;
  logic [8:0] count_inc;
  logic       overflow;
  logic       frame_end;
  logic [7:0] b;

  assign rx.ready = !full_i;
  assign accept   = rx.valid && !full_i;

  always_comb begin
    b     = rx.rx_byte;
    first = (byte_count_q == '0);

    frame_length_d = first ? b : frame_length_q;
    expected_sum_d = first ? 8'h00 : expected_sum_q;
    command_d      = first ? 8'h00 : command_q;
    running_sum_d  = first ? 8'h00 : running_sum_q;
    size_capture_d = first ? 32'h0 : size_capture_q;

    if (byte_count_q == 9'd2) expected_sum_d = b;
    if (byte_count_q == 9'd3) command_d = b;
    if (byte_count_q >= 9'd3) running_sum_d = running_sum_d + b;

    // The file size arrives big-endian in four consecutive bytes.
    case (byte_count_q)
      SIZE_IDX_FIRST:         size_capture_d = size_capture_d | {b, 24'h0};
      SIZE_IDX_FIRST + 9'd1:  size_capture_d = size_capture_d | {8'h0, b, 16'h0};
      SIZE_IDX_FIRST + 9'd2:  size_capture_d = size_capture_d | {16'h0, b, 8'h0};
      SIZE_IDX_FIRST + 9'd3:  size_capture_d = size_capture_d | {24'h0, b};
      default:                size_capture_d = size_capture_d;
    endcase

    count_inc = byte_count_q + 9'd1;
    overflow  = count_inc > 9'(FRAME_LIMIT);
    frame_end = !overflow && (count_inc == ({1'b0, frame_length_d} + FRAME_OVERHEAD));

    image_pos_d = image_pos_q;
    image_len_d = image_len_q;

    job_o.is_reply = 1'b0;
    job_o.reply    = REPLY_0A;
    job_o.status   = STATUS_OK;
    job_o.command  = command_d;

    if (overflow) begin
      job_o.status = STATUS_OVF;
    end else if (frame_end) begin
      if (running_sum_d != expected_sum_d) begin
        job_o.status = STATUS_CSUM;
      end else begin
        case (command_d)
          CMD_SET_SIZE: begin
            image_pos_d    = 32'h0;
            image_len_d    = size_capture_d;
            job_o.is_reply = 1'b1;
            job_o.reply    = REPLY_0A;
          end
          CMD_DATA: begin
            image_pos_d    = image_pos_q + {24'h0, frame_length_d};
            job_o.is_reply = 1'b1;
            job_o.reply    = REPLY_0B;
          end
          CMD_INFO: begin
            job_o.is_reply = 1'b1;
            job_o.reply    = REPLY_04;
          end
          CMD_CONFIG: begin
            job_o.is_reply = 1'b1;
            job_o.reply    = REPLY_0F;
          end
          CMD_STATUS: begin
            job_o.is_reply = 1'b0;
          end
          default: begin
            job_o.is_reply = 1'b0;
          end
        endcase
      end
    end

    job_o.image_pos = image_pos_d;
    job_o.image_len = image_len_d;

    byte_count_d = (overflow || frame_end) ? 9'd0 : count_inc;
    push_o       = accept && (overflow || frame_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      frame_length_q <= '0;
      expected_sum_q <= '0;
      command_q      <= '0;
      running_sum_q  <= '0;
      size_capture_q <= '0;
      image_pos_q    <= '0;
      image_len_q    <= '0;
    end else if (accept) begin
      byte_count_q   <= byte_count_d;
      frame_length_q <= frame_length_d;
      expected_sum_q <= expected_sum_d;
      command_q      <= command_d;
      running_sum_q  <= running_sum_d;
      size_capture_q <= size_capture_d;
      image_pos_q    <= image_pos_d;
      image_len_q    <= image_len_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ufcr_queue.sv =====
// Small job queue that decouples frame checking from reply generation.
`default_nettype none

module ufcr_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  ufcr_pkg::job_t push_job_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output ufcr_pkg::job_t head_o,
  output logic           empty_o
);
  import ufcr_pkg::*;

  job_t mem_q [QUEUE_DEPTH];

  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ufcr_back.sv =====
// Back end: expands queued jobs into reply bytes or status reports.
`default_nettype none

module ufcr_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  ufcr_pkg::job_t head_i,
  input  wire logic      empty_i,
  output logic           pop_o,
  ufcr_tx_if.source      tx
);
  import ufcr_pkg::*;

  logic [REPLY_IW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic                tx_valid_q, tx_valid_d;
  logic [7:0]          tx_byte_q, tx_byte_d;
  logic                last_q, last_d;
  logic [1:0]          status_q, status_d;
  logic [7:0]          command_q, command_d;
  logic [31:0]         image_pos_q, image_pos_d;
  logic [31:0]         image_len_q, image_len_d;

  logic load;
  logic final_byte;

  always_comb begin
    load       = !empty_i && (!out_valid_q || tx.ready);
    final_byte = !head_i.is_reply || (idx_q == REPLY_LEN[head_i.reply] - 1'b1);
    pop_o      = load && final_byte;

    idx_d = idx_q;
    if (load) idx_d = final_byte ? '0 : idx_q + 1'b1;

    out_valid_d = load ? 1'b1 : (tx.ready ? 1'b0 : out_valid_q);

    tx_valid_d  = head_i.is_reply;
    tx_byte_d   = head_i.is_reply ? REPLY_ROM[head_i.reply][idx_q] : 8'h00;
    last_d      = final_byte;
    status_d    = head_i.status;
    command_d   = head_i.command;
    image_pos_d = head_i.image_pos;
    image_len_d = head_i.image_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_valid_q  <= tx_valid_d;
      tx_byte_q   <= tx_byte_d;
      last_q      <= last_d;
      status_q    <= status_d;
      command_q   <= command_d;
      image_pos_q <= image_pos_d;
      image_len_q <= image_len_d;
    end
  end

  assign tx.valid     = out_valid_q;
  assign tx.tx_valid  = tx_valid_q;
  assign tx.tx_byte   = tx_byte_q;
  assign tx.last      = last_q;
  assign tx.status    = status_q;
  assign tx.command   = command_q;
  assign tx.image_pos = image_pos_q;
  assign tx.image_len = image_len_q;

endmodule

`default_nettype wire
